// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the look-at view matrix RTL.
// Defining NO_ASSERTIONS compiles every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define LVM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define LVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LVM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/core/lvm_pkg.sv -----
// Types, register codes and saturation helper for the look-at view matrix.
// No dependencies; every other file of the block but the assertion macro header imports this package.
package lvm_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WORD_W:0]   t_diff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X = 2'd0,
        CFG_SCALE_Y = 2'd1,
        CFG_SCALE_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_word [2:0] eye;
        t_word [2:0] hint;
        t_diff [2:0] diff;
    } t_item;

    function automatic t_word sat32(input logic signed [65:0] v);
        t_word r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/lvm_if.sv -----
// Channel interfaces of the look-at view matrix block: input, result, config.
// Depends on lvm_pkg for the field types.
interface lvm_in_if;
    import lvm_pkg::*;
    logic  valid;
    logic  ready;
    t_word eye_x;
    t_word eye_y;
    t_word eye_z;
    t_word target_x;
    t_word target_y;
    t_word target_z;
    t_word up_hint_x;
    t_word up_hint_y;
    t_word up_hint_z;
    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_hint_x, up_hint_y, up_hint_z, input ready);
    modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_hint_x, up_hint_y, up_hint_z, output ready);
endinterface

interface lvm_out_if;
    import lvm_pkg::*;
    logic       valid;
    logic       ready;
    logic [3:0] entry_index;
    t_word      entry_value;
    logic       degenerate;
    logic       last_entry;
    modport source (output valid, entry_index, entry_value, degenerate, last_entry,
                    input ready);
    modport sink (input valid, entry_index, entry_value, degenerate, last_entry,
                  output ready);
endinterface

interface lvm_cfg_if;
    import lvm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_word                data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lvm_front.sv -----
// Front stage: takes input transfers, forms target minus eye exactly in 33 bits.
// Depends on lvm_pkg and lvm_in_if.
module lvm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lvm_in_if.sink           i_in,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output lvm_pkg::t_item   o_push_item
);
    import lvm_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  take;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign take         = i_in.valid && i_in.ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.eye     <= {i_in.eye_z, i_in.eye_y, i_in.eye_x};
            r_item.hint    <= {i_in.up_hint_z, i_in.up_hint_y, i_in.up_hint_x};
            r_item.diff[0] <= 33'($signed(i_in.target_x)) - 33'($signed(i_in.eye_x));
            r_item.diff[1] <= 33'($signed(i_in.target_y)) - 33'($signed(i_in.eye_y));
            r_item.diff[2] <= 33'($signed(i_in.target_z)) - 33'($signed(i_in.eye_z));
        end
    end

endmodule

// ----- rtl/core/lvm_queue.sv -----
// Short item queue between the front stage and the matrix engine.
// Depends on lvm_pkg for the item type.
module lvm_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  lvm_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output lvm_pkg::t_item o_pop_item
);
    import lvm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/core/lvm_back.sv -----
// Matrix engine: one shared multiplier, a bit-serial square root and divider,
// then sixteen result transfers. Depends on lvm_pkg and lvm_out_if.
module lvm_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_pop_valid,
    output logic                     o_pop_ready,
    input  lvm_pkg::t_item           i_item,
    input  lvm_pkg::t_word [2:0]     i_scale,
    lvm_out_if.source                o_out
);
    import lvm_pkg::*;

    localparam int NW    = WORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FWD   = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_SQRT  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_CROSS = 8'b0010_0000,
        S_DOT   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_item              r_item;
    t_word [2:0]        r_fwd;
    t_word [2:0]        r_side;
    t_word [2:0]        r_up;
    t_word [2:0]        r_dot;
    logic [1:0]         r_i;
    logic [1:0]         r_j;
    logic               r_vsel;
    logic               r_degen;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [65:0] r_acc;
    logic [63:0]        r_sqx;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_len;
    logic [31:0]        r_rem;
    logic [NW-1:0]      r_num;
    logic [3:0]         r_emit_idx;
    logic               r_ovalid;
    logic [3:0]         r_oidx;
    t_word              r_oval;
    logic               r_odeg;
    logic               r_olast;

    logic [1:0]         nx1;
    logic [1:0]         nx2;
    t_word [2:0]        vcur;
    t_word [2:0]        src_a;
    t_word [2:0]        src_b;
    t_word [2:0]        dot_v;
    logic signed [33:0] mul_a;
    t_word              mul_b;
    logic signed [65:0] prod;
    logic signed [65:0] qprod;
    logic signed [65:0] n_acc;
    logic [63:0]        sq_t;
    logic               sq_ge;
    logic [63:0]        n_res;
    logic [63:0]        n_sqx;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic [31:0]        n_rem;
    logic [NW-1:0]      n_num;
    logic               q_big;
    t_word              norm_val;
    t_word              cur_val;
    t_word              nxt_val;
    logic [31:0]        nxt_mag;
    t_word              cross_val;
    t_word              entry_val;
    logic [1:0]         e_col;
    logic [1:0]         e_row;
    logic               emit_take;

    assign nx1   = (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
    assign nx2   = (r_i == 2'd0) ? 2'd2 : r_i - 2'd1;
    assign vcur  = r_vsel ? r_side : r_fwd;
    assign src_a = r_vsel ? r_side : r_fwd;
    assign src_b = r_vsel ? r_fwd : r_item.hint;
    assign dot_v = (r_i == 2'd0) ? r_side : ((r_i == 2'd1) ? r_up : r_fwd);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_FWD: begin
                mul_a = 34'($signed(r_item.diff[r_i]));
                mul_b = i_scale[r_i];
            end
            S_SQ: begin
                mul_a = 34'($signed(vcur[r_i]));
                mul_b = vcur[r_i];
            end
            S_CROSS: begin
                if (r_j == 2'd0) begin
                    mul_a = 34'($signed(src_a[nx1]));
                    mul_b = src_b[nx2];
                end else begin
                    mul_a = 34'($signed(src_a[nx2]));
                    mul_b = src_b[nx1];
                end
            end
            S_DOT: begin
                mul_a = 34'($signed(dot_v[r_j]));
                mul_b = r_item.eye[r_j];
            end
            default: begin
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign qprod = prod >>> FRAC_BITS;
    assign n_acc = r_acc + ((r_state == S_SQ) ? prod : qprod);

    assign sq_t  = r_res + r_bit;
    assign sq_ge = r_sqx >= sq_t;
    assign n_res = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
    assign n_sqx = sq_ge ? r_sqx - sq_t : r_sqx;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign qbit   = rem_sh >= {1'b0, r_len};
    assign n_rem  = qbit ? 32'(rem_sh - {1'b0, r_len}) : rem_sh[31:0];
    assign n_num  = {r_num[NW-2:0], qbit};
    assign q_big  = |n_num[NW-1:31];
    assign cur_val = vcur[r_i];

    always_comb begin
        if (cur_val[31]) begin
            norm_val = q_big ? 32'sh8000_0000 : t_word'(-n_num[31:0]);
        end else begin
            norm_val = q_big ? 32'sh7FFF_FFFF : t_word'(n_num[31:0]);
        end
    end

    assign nxt_val   = vcur[nx1];
    assign nxt_mag   = nxt_val[31] ? 32'(-nxt_val) : 32'(nxt_val);
    assign cross_val = sat32(r_acc - qprod);

    assign e_col = r_emit_idx[3:2];
    assign e_row = r_emit_idx[1:0];

    always_comb begin
        entry_val = '0;
        if (!r_degen) begin
            if (e_col != 2'd3) begin
                unique case (e_row)
                    2'd0: entry_val = r_side[e_col];
                    2'd1: entry_val = r_up[e_col];
                    2'd2: entry_val = sat32(-66'($signed(r_fwd[e_col])));
                    default: entry_val = '0;
                endcase
            end else begin
                unique case (e_row)
                    2'd0: entry_val = r_dot[0];
                    2'd1: entry_val = r_dot[1];
                    2'd2: entry_val = r_dot[2];
                    default: entry_val = t_word'(1) <<< FRAC_BITS;
                endcase
            end
        end
    end

    assign emit_take   = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);
    assign o_pop_ready = r_state == S_IDLE;

    assign o_out.valid       = r_ovalid;
    assign o_out.entry_index = r_oidx;
    assign o_out.entry_value = r_oval;
    assign o_out.degenerate  = r_odeg;
    assign o_out.last_entry  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (emit_take) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_state <= S_FWD;
                    end
                end
                S_FWD: begin
                    if (r_i == 2'd2) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_i == 2'd2) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == CNT_W'(31)) begin
                        r_state <= (n_res[31:0] == '0) ? S_EMIT : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(NW - 1) && r_i == 2'd2) begin
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    if (r_i == 2'd2 && r_j == 2'd1) begin
                        r_state <= r_vsel ? S_DOT : S_SQ;
                    end
                end
                S_DOT: begin
                    if (r_i == 2'd2 && r_j == 2'd2) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_take && r_emit_idx == 4'hF) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_take) begin
            r_oidx  <= r_emit_idx;
            r_oval  <= entry_val;
            r_odeg  <= r_degen;
            r_olast <= r_emit_idx == 4'hF;
        end
        unique case (r_state)
            S_IDLE: begin
                r_item     <= i_item;
                r_i        <= '0;
                r_j        <= '0;
                r_vsel     <= 1'b0;
                r_degen    <= 1'b0;
                r_acc      <= '0;
                r_emit_idx <= '0;
            end
            S_FWD: begin
                r_fwd[r_i] <= sat32(qprod);
                r_i        <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            S_SQ: begin
                r_acc <= n_acc;
                r_i   <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                r_sqx <= n_acc[63:0];
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            S_SQRT: begin
                r_sqx <= n_sqx;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                r_len <= n_res[31:0];
                r_rem <= '0;
                r_num <= {(cur_val[31] ? 32'(-cur_val) : 32'(cur_val)), FRAC_BITS'(0)};
                r_emit_idx <= '0;
                if (r_cnt == CNT_W'(31)) begin
                    r_cnt   <= '0;
                    r_degen <= n_res[31:0] == '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(NW - 1)) begin
                    if (r_vsel) begin
                        r_side[r_i] <= norm_val;
                    end else begin
                        r_fwd[r_i] <= norm_val;
                    end
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_num <= {nxt_mag, FRAC_BITS'(0)};
                    r_i   <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                    r_j   <= '0;
                end else begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_CROSS: begin
                if (r_j == 2'd0) begin
                    r_acc <= qprod;
                    r_j   <= 2'd1;
                end else begin
                    if (r_vsel) begin
                        r_up[r_i] <= cross_val;
                    end else begin
                        r_side[r_i] <= cross_val;
                    end
                    r_j   <= '0;
                    r_acc <= '0;
                    r_i   <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                    if (r_i == 2'd2) begin
                        r_vsel <= 1'b1;
                    end
                end
            end
            S_DOT: begin
                if (r_j == 2'd2) begin
                    r_dot[r_i] <= (r_i == 2'd2) ? sat32(n_acc) : sat32(-n_acc);
                    r_acc      <= '0;
                    r_j        <= '0;
                    r_i        <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                end else begin
                    r_acc <= n_acc;
                    r_j   <= r_j + 2'd1;
                end
                r_emit_idx <= '0;
            end
            S_EMIT: begin
                if (emit_take) begin
                    r_emit_idx <= r_emit_idx + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/lookat_view_matrix_core.sv -----
// Channel    Dir  Width  Transfer carries
// i_in       in   288    eye, target and up hint, signed fixed point
// o_out      out  38     one matrix entry: index, value, degenerate, last
// i_cfg      in   34     forward scale register index and data
//
// Each input item yields sixteen result transfers, column-major.
// The engine runs the bit-serial square root and divider twice per item: for
// the forward vector, then for the side vector.
// A zero-length forward vector ends the item after the first square root,
// a zero-length side vector after the second one.
// Reset is synchronous and active low; the scale registers reset to 1.0.
// A stalled output holds the engine; the front and the queue keep taking items until both are full.
`include "assert_macros.svh"
module lookat_view_matrix_core #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lvm_in_if.sink    i_in,
    lvm_out_if.source o_out,
    lvm_cfg_if.sink   i_cfg
);
    import lvm_pkg::*;

    t_word r_scale_x;
    t_word r_scale_y;
    t_word r_scale_z;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= t_word'(1) <<< FRAC_BITS;
            r_scale_y <= t_word'(1) <<< FRAC_BITS;
            r_scale_z <= t_word'(1) <<< FRAC_BITS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SCALE_X: r_scale_x <= i_cfg.data;
                CFG_SCALE_Y: r_scale_y <= i_cfg.data;
                CFG_SCALE_Z: r_scale_z <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    lvm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    lvm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    lvm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_item      (pop_item),
        .i_scale     ({r_scale_z, r_scale_y, r_scale_x}),
        .o_out       (o_out)
    );

    `LVM_ASSERT(a_degen_zero, i_clk, i_rst_n, (o_out.valid && o_out.degenerate) |-> (o_out.entry_value == '0), "degenerate entry is not zero")
    `LVM_ASSERT(a_last_index, i_clk, i_rst_n, (o_out.valid && o_out.last_entry) |-> (o_out.entry_index == 4'hF), "last entry flag on wrong index")
    `LVM_ASSERT(a_push_hold, i_clk, i_rst_n, (push_valid && !push_ready) |=> push_valid, "front dropped a stalled item")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for lookat_view_matrix_core: drives eye, target and
// up hint items and checks all sixteen matrix entries against a local predictor.
// Depends on lvm_pkg and the lvm_in_if, lvm_out_if and lvm_cfg_if interfaces.
`timescale 1ns / 1ps
module tb_top;
    import lvm_pkg::*;

    localparam int FRAC = 16;
    localparam int HOLD_CYCLES = 1200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam t_word ONE = 32'sd65536;
    localparam t_word WMAX = 32'sh7FFF_FFFF;
    localparam t_word WMIN = 32'sh8000_0000;

    typedef logic signed [127:0] wide_t;
    typedef struct {
        t_word eye[3];
        t_word tgt[3];
        t_word hint[3];
    } view_req_t;
    typedef struct {
        logic [3:0] index;
        t_word      value;
        logic       degen;
        logic       last;
    } entry_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lvm_in_if  in_ch();
    lvm_out_if out_ch();
    lvm_cfg_if cfg_ch();

    lookat_view_matrix_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    t_word  scale_reg[3];
    entry_t entry_q[$];
    int     err_count = 0;
    bit     hold_req = 1'b0;
    bit     no_stall = 1'b0;

    function automatic wide_t clamp32(wide_t v);
        if (v > wide_t'(WMAX)) return wide_t'(WMAX);
        if (v < wide_t'(WMIN)) return wide_t'(WMIN);
        return v;
    endfunction

    function automatic wide_t fx_mul(wide_t a, wide_t b);
        wide_t p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic wide_t int_sqrt(wide_t x);
        logic [127:0] rem, res, bitv;
        rem = x;
        res = 0;
        bitv = 128'd1 << 70;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return wide_t'(res);
    endfunction

    function automatic bit unit_vec(ref wide_t v[3]);
        wide_t sum, len, mag, q;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += v[i] * v[i];
        len = int_sqrt(sum);
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            q = (mag << FRAC) / len;
            v[i] = clamp32((v[i] < 0) ? -q : q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_vec(ref wide_t r[3], ref wide_t a[3], ref wide_t b[3]);
        r[0] = clamp32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
        r[1] = clamp32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
        r[2] = clamp32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
    endfunction

    function automatic wide_t dot_vec(ref wide_t a[3], ref wide_t b[3]);
        return fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
    endfunction

    function automatic void predict_view(view_req_t r);
        wide_t eye[3], fwd[3], side[3], up[3], hint[3];
        wide_t m[16];
        bit    degen;
        entry_t e;
        for (int i = 0; i < 3; i++) begin
            eye[i] = r.eye[i];
            hint[i] = r.hint[i];
            fwd[i] = clamp32(fx_mul(wide_t'(r.tgt[i]) - wide_t'(r.eye[i]),
                                    wide_t'(scale_reg[i])));
        end
        degen = 1'b0;
        if (!unit_vec(fwd)) begin
            degen = 1'b1;
        end else begin
            cross_vec(side, fwd, hint);
            if (!unit_vec(side)) degen = 1'b1;
        end
        for (int i = 0; i < 16; i++) m[i] = 0;
        if (!degen) begin
            cross_vec(up, side, fwd);
            for (int i = 0; i < 3; i++) begin
                m[4*i]   = side[i];
                m[4*i+1] = up[i];
                m[4*i+2] = clamp32(-fwd[i]);
            end
            m[12] = clamp32(-dot_vec(side, eye));
            m[13] = clamp32(-dot_vec(up, eye));
            m[14] = clamp32(dot_vec(fwd, eye));
            m[15] = wide_t'(ONE);
        end
        for (int i = 0; i < 16; i++) begin
            e.index = i[3:0];
            e.value = m[i][31:0];
            e.degen = degen;
            e.last = (i == 15);
            entry_q.push_back(e);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_word rand_mid();
        return t_word'(int'($urandom_range(0, 2097152)) - 1048576);
    endfunction

    task automatic send_view(view_req_t r);
        in_ch.eye_x <= r.eye[0];
        in_ch.eye_y <= r.eye[1];
        in_ch.eye_z <= r.eye[2];
        in_ch.target_x <= r.tgt[0];
        in_ch.target_y <= r.tgt[1];
        in_ch.target_z <= r.tgt[2];
        in_ch.up_hint_x <= r.hint[0];
        in_ch.up_hint_y <= r.hint[1];
        in_ch.up_hint_z <= r.hint[2];
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_view(r);
    endtask

    task automatic pause_input(int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_paced(view_req_t r);
        send_view(r);
        pause_input(no_stall ? 0 : pick_gap());
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (entry_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_word data);
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx <= CFG_SCALE_Z) scale_reg[idx] = data;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_scales(t_word sx, t_word sy, t_word sz);
        drain();
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        write_reg(CFG_SCALE_Z, sz);
    endtask

    function automatic view_req_t make_view(t_word ex, t_word ey, t_word ez,
                                            t_word tx, t_word ty, t_word tz,
                                            t_word ux, t_word uy, t_word uz);
        view_req_t r;
        r.eye = '{ex, ey, ez};
        r.tgt = '{tx, ty, tz};
        r.hint = '{ux, uy, uz};
        return r;
    endfunction

    function automatic view_req_t rand_view();
        view_req_t r;
        int kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (kind < 75) begin
                r.eye[i] = rand_mid();
                r.tgt[i] = rand_mid();
                r.hint[i] = rand_mid();
            end else begin
                r.eye[i] = $urandom;
                r.tgt[i] = $urandom;
                r.hint[i] = $urandom;
            end
        end
        if (kind >= 90 && kind < 95) r.tgt = r.eye;
        if (kind >= 95) begin
            for (int i = 0; i < 3; i++) r.hint[i] = r.tgt[i] - r.eye[i];
        end
        return r;
    endfunction

    task automatic test_directed_views();
        send_paced(make_view(0, 0, ONE * 5, 0, 0, 0, 0, ONE, 0));
        send_paced(make_view(ONE, ONE * 2, ONE * 3, -ONE, 0, ONE, 0, 0, ONE));
        send_paced(make_view(7, 7, 7, 7, 7, 7, 0, ONE, 0));
        send_paced(make_view(0, 0, 0, ONE, 0, 0, ONE * 3, 0, 0));
        send_paced(make_view(0, 0, 0, ONE, 0, 0, 0, 0, 0));
        send_paced(make_view(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMAX, WMIN, WMAX));
        send_paced(make_view(WMIN, 0, WMAX, WMAX, 0, WMIN, 0, WMAX, 0));
        send_paced(make_view(WMAX, WMIN, 0, WMIN, WMAX, 1, WMIN, WMIN, WMIN));
        send_paced(make_view(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_paced(make_view(-1, -1, -1, -1, -1, -2, -1, -1, -1));
        send_paced(make_view(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                             32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0,
                             32'sh3333_3333, 32'shCCCC_CCCC, 32'sh7F7F_7F7F));
        drain();
    endtask

    task automatic test_scale_settings();
        view_req_t v;
        v = make_view(ONE, -ONE * 2, ONE * 3, ONE * 4, ONE, -ONE, ONE, ONE, 0);
        set_scales(0, ONE, ONE);
        send_paced(v);
        set_scales(0, 0, 0);
        send_paced(v);
        set_scales(WMAX, WMIN, WMAX);
        send_paced(v);
        send_paced(make_view(WMIN, WMAX, 0, WMAX, WMIN, 1, 0, 0, ONE));
        set_scales(WMIN, WMAX, -ONE);
        send_paced(v);
        set_scales(-ONE, ONE / 2, ONE * 3);
        send_paced(v);
        drain();
        write_reg(CFG_UNUSED, 32'sh1234_5678);
        send_paced(v);
        set_scales(ONE, ONE, ONE);
        send_paced(v);
        drain();
    endtask

    task automatic test_random_views();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_scales(ONE, ONE, ONE);
                1: set_scales(t_word'(int'($urandom_range(0, 262144)) - 131072),
                              t_word'(int'($urandom_range(0, 262144)) - 131072),
                              t_word'(int'($urandom_range(0, 262144)) - 131072));
                2: set_scales($urandom, $urandom, $urandom);
                default: set_scales(ONE * 2, -ONE, ONE / 4);
            endcase
            no_stall = (phase == 3);
            for (int n = 0; n < 45; n++) send_paced(rand_view());
        end
        no_stall = 1'b0;
        drain();
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        for (int n = 0; n < 10; n++) send_view(rand_view());
        drain();
    endtask

    initial begin
        int slots;
        while (1) begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                slots = 0;
                while (slots < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    slots++;
                end
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (no_stall) begin
                out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) < 75);
            end
        end
    end

    always @(posedge i_clk) begin
        entry_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (entry_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected entry transfer: index %0d value %0d",
                             out_ch.entry_index, out_ch.entry_value);
                end
            end else begin
                e = entry_q.pop_front();
                if (out_ch.entry_index !== e.index || out_ch.entry_value !== e.value
                        || out_ch.degenerate !== e.degen || out_ch.last_entry !== e.last) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("entry mismatch: exp idx %0d val %0d deg %0b last %0b",
                                 e.index, e.value, e.degen, e.last);
                        $display("                got idx %0d val %0d deg %0b last %0b",
                                 out_ch.entry_index, out_ch.entry_value,
                                 out_ch.degenerate, out_ch.last_entry);
                    end
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("lookat_view_matrix_core regression: fail");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.eye_x <= '0;
        in_ch.eye_y <= '0;
        in_ch.eye_z <= '0;
        in_ch.target_x <= '0;
        in_ch.target_y <= '0;
        in_ch.target_z <= '0;
        in_ch.up_hint_x <= '0;
        in_ch.up_hint_y <= '0;
        in_ch.up_hint_z <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        out_ch.ready <= 1'b0;
        scale_reg = '{ONE, ONE, ONE};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_views();
        test_scale_settings();
        test_random_views();
        test_output_backpressure();
        if (err_count == 0 && entry_q.size() == 0) begin
            $display("lookat_view_matrix_core regression: pass");
        end else begin
            $display("lookat_view_matrix_core regression: fail");
        end
        $finish;
    end
endmodule
